// ----- hw/rtl/ppmfd_pkg.sv -----
// shared widths, codes, reset values and types of the ppm frame decoder
package ppmfd_pkg;

   localparam int unsigned TIME_W           = 16;
   localparam int unsigned VALUE_W          = 16;
   localparam int unsigned CHAN_W           = 3;
   localparam int unsigned STATUS_W         = 2;
   localparam int unsigned CSR_INDEX_W      = 8;
   localparam int unsigned CSR_DATA_W       = 16;
   localparam int unsigned NUM_CHANNELS_DEF = 8;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_SYNC   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_STORED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_GAP      = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_WIDTH     = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_WIDTH     = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_OFFSET = 8'd3;

   // register reset values
   localparam logic [TIME_W-1:0] SYNC_GAP_RST      = 16'd10000;
   localparam logic [TIME_W-1:0] MIN_WIDTH_RST     = 16'd400;
   localparam logic [TIME_W-1:0] MAX_WIDTH_RST     = 16'd4400;
   localparam logic [TIME_W-1:0] CENTER_OFFSET_RST = 16'd3000;

   typedef struct packed {
      logic [TIME_W-1:0] sync_gap;
      logic [TIME_W-1:0] min_width;
      logic [TIME_W-1:0] max_width;
      logic [TIME_W-1:0] center_offset;
   } cfg_type;

endpackage

// ----- hw/rtl/ppmfd_if.sv -----
// channel interfaces of the ppm frame decoder: edge words, result words, register writes

interface ppmfd_req_if;
   import ppmfd_pkg::*;
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] capture_time;
   modport source (output valid, output capture_time, input ready);
   modport sink   (input valid, input capture_time, output ready);
endinterface

interface ppmfd_rsp_if;
   import ppmfd_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic [CHAN_W-1:0]         channel;
   logic signed [VALUE_W-1:0] value;
   logic                      frame_done;
   modport source (output valid, output status, output channel, output value,
                   output frame_done, input ready);
   modport sink   (input valid, input status, input channel, input value,
                   input frame_done, output ready);
endinterface

interface ppmfd_csr_if;
   import ppmfd_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/ppmfd_csr.sv -----
// configuration registers of the ppm frame decoder
module ppmfd_csr (
   input  logic              clock,
   input  logic              reset,
   ppmfd_csr_if.sink         csr_chan,
   output ppmfd_pkg::cfg_type cfg
);
   import ppmfd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_SYNC_GAP:      cfg_in.sync_gap      = csr_chan.data[TIME_W-1:0];
            CSR_MIN_WIDTH:     cfg_in.min_width     = csr_chan.data[TIME_W-1:0];
            CSR_MAX_WIDTH:     cfg_in.max_width     = csr_chan.data[TIME_W-1:0];
            CSR_CENTER_OFFSET: cfg_in.center_offset = csr_chan.data[TIME_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_gap      <= SYNC_GAP_RST;
         cfg_ff.min_width     <= MIN_WIDTH_RST;
         cfg_ff.max_width     <= MAX_WIDTH_RST;
         cfg_ff.center_offset <= CENTER_OFFSET_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/ppm_frame_decoder.sv -----
// top level of the ppm frame decoder: edge gap classification and channel position tracking
//
// req_chan carries one capture_time word per signal edge; rsp_chan returns exactly one
// result word per edge (status, channel, value, frame_done) in arrival order.
// csr_chan writes the four timing registers (sync gap, min width, max width, center
// offset) at indexes 0 to 3; other indexes are ignored. csr_chan is always ready. The
// user must see that registers are written only while no edge is in flight; the
// block itself does not enforce it. An accepted word passes through the input register
// and then the result register before it shows on rsp_chan. Throughput: one word per
// cycle while rsp_chan does not stall, set by the single subtract-and-compare step
// between the input register and the result register, which also updates the previous
// capture and the channel position. Reset clears the previous capture and the position
// to zero, loads the register defaults and empties both pipeline registers. When the
// receiver stalls, the result register holds its word, one more edge waits in the input
// register, and then req_chan.ready drops until rsp_chan takes the held word.
module ppm_frame_decoder #(
   parameter int unsigned NumChannels = ppmfd_pkg::NUM_CHANNELS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   ppmfd_req_if.sink    req_chan,
   ppmfd_rsp_if.source  rsp_chan,
   ppmfd_csr_if.sink    csr_chan
);
   import ppmfd_pkg::*;

   localparam int unsigned PosW = (NumChannels > 1) ? $clog2(NumChannels) : 1;
   localparam logic [PosW-1:0] LastPos = PosW'(NumChannels - 1);

   cfg_type cfg;

   ppmfd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // input register
   logic              s1_valid_ff;
   logic [TIME_W-1:0] s1_time_ff;

   // decoder state
   logic [TIME_W-1:0] last_time_ff;
   logic [PosW-1:0]   pos_ff;
   logic [PosW-1:0]   pos_in;

   // result register
   logic                      out_valid_ff;
   logic [STATUS_W-1:0]       out_status_ff;
   logic [STATUS_W-1:0]       out_status_in;
   logic [CHAN_W-1:0]         out_channel_ff;
   logic [CHAN_W-1:0]         out_channel_in;
   logic signed [VALUE_W-1:0] out_value_ff;
   logic signed [VALUE_W-1:0] out_value_in;
   logic                      out_done_ff;
   logic                      out_done_in;

   logic              out_adv;
   logic              s1_go;
   logic              in_take;
   logic [TIME_W-1:0] gap;
   logic              is_sync;
   logic              is_pulse;
   logic              last_slot;

   assign out_adv = !out_valid_ff || rsp_chan.ready;
   assign s1_go   = s1_valid_ff && out_adv;
   assign in_take = !s1_valid_ff || out_adv;

   assign req_chan.ready = in_take;

   // modulo 2^16 gap since the previous edge
   assign gap       = s1_time_ff - last_time_ff;
   assign is_sync   = gap > cfg.sync_gap;
   assign is_pulse  = (gap > cfg.min_width) && (gap < cfg.max_width);
   assign last_slot = pos_ff == LastPos;

   always_comb begin
      pos_in         = '0;
      out_status_in  = ST_REJECT;
      out_channel_in = '0;
      out_value_in   = '0;
      out_done_in    = 1'b0;
      if (is_sync) begin
         out_status_in = ST_SYNC;
      end else if (is_pulse) begin
         out_status_in  = ST_STORED;
         out_channel_in = CHAN_W'(pos_ff);
         out_value_in   = VALUE_W'(gap - cfg.center_offset);
         out_done_in    = last_slot;
         pos_in         = last_slot ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (in_take) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take && req_chan.valid) begin
         s1_time_ff <= req_chan.capture_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         pos_ff       <= '0;
      end else if (s1_go) begin
         last_time_ff <= s1_time_ff;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_adv) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         out_status_ff  <= out_status_in;
         out_channel_ff <= out_channel_in;
         out_value_ff   <= out_value_in;
         out_done_ff    <= out_done_in;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.status     = out_status_ff;
   assign rsp_chan.channel    = out_channel_ff;
   assign rsp_chan.value      = out_value_ff;
   assign rsp_chan.frame_done = out_done_ff;

endmodule

// ----- hw/rtl/ppmfd_checker.sv -----
// port-level assertions for the ppm frame decoder, bound to the top level
module ppmfd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [ppmfd_pkg::STATUS_W-1:0]      status,
   input logic [ppmfd_pkg::CHAN_W-1:0]        channel,
   input logic signed [ppmfd_pkg::VALUE_W-1:0] value,
   input logic                                frame_done
);
   import ppmfd_pkg::*;

   // a stalled result word holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(channel)
         && $stable(value) && $stable(frame_done))
      else $error("result word changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (status == ST_SYNC || status == ST_STORED || status == ST_REJECT))
      else $error("unknown status code");

   // only a stored pulse carries channel, value and frame end
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != ST_STORED |-> channel == '0 && value == '0 && !frame_done)
      else $error("fields set on a sync or rejected word");

   a_done_stored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_done |-> status == ST_STORED)
      else $error("frame end without a stored pulse");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word present right after reset");

endmodule

bind ppm_frame_decoder ppmfd_checker u_ppmfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .status     (rsp_chan.status),
   .channel    (rsp_chan.channel),
   .value      (rsp_chan.value),
   .frame_done (rsp_chan.frame_done)
);
